### design/median_filter_3x3_assert.svh
// Assertion macros for the median filter RTL.
// Included by mf3_front, which checks its own pipeline behavior; needs no package.
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MF3_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MF3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/mf3_pkg.sv
// Package for the 3x3 median filter: sizes, register codes, shared types and
// the compare functions used by the sorting pipeline. No dependencies.
package mf3_pkg;

   localparam int MAX_COLS   = 2048;
   localparam int MAX_ROWS   = 2048;
   localparam int PIX_W      = 8;
   localparam int DIM_W      = 12;
   localparam int POS_W      = 11;
   localparam int ADDR_W     = $clog2(MAX_COLS);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int MIN_DIM    = 3;

   // Line memory word: upper row and middle row of one column
   localparam int LB_WORD_W  = 2 * PIX_W;

   localparam logic [DIM_W-1:0] COLS_RESET = 12'd1024;
   localparam logic [DIM_W-1:0] ROWS_RESET = 12'd768;

   // Register index, taken from the word-address bit of paddr
   localparam logic REG_IMAGE_COLS = 1'b0;
   localparam logic REG_IMAGE_ROWS = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;

   // Nine window taps, index 0..2 top row, 3..5 middle row, 6..8 bottom row
   typedef logic [8:0][PIX_W-1:0] win_type;

   typedef struct packed {
      logic [DIM_W-1:0] cols;
      logic [DIM_W-1:0] rows;
   } dims_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } pos_type;

   typedef struct packed {
      pix_type lo;
      pix_type md;
      pix_type hi;
   } col3_type;

   function automatic pix_type min2(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type max2(input pix_type a, input pix_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic col3_type sort3(input pix_type a, input pix_type b, input pix_type c);
      col3_type res;
      res.lo = min2(min2(a, b), c);
      res.md = med3(a, b, c);
      res.hi = max2(max2(a, b), c);
      return res;
   endfunction

   // Saturate a dimension register to [MIN_DIM, hi]
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] res;
      if (v < DIM_W'(MIN_DIM)) begin
         res = DIM_W'(MIN_DIM);
      end else if (v > hi) begin
         res = hi;
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

### design/mf3_stream_if.sv
// Stream interfaces of the median filter: pixel request channel and result
// response channel, valid/ready handshake. Depends on mf3_pkg.
interface mf3_req_if;
   logic                       valid;
   logic                       ready;
   logic [mf3_pkg::PIX_W-1:0]  pixel;
   logic                       start_of_frame;

   modport source (output valid, output pixel, output start_of_frame, input ready);
   modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface mf3_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mf3_pkg::PIX_W-1:0]  median_value;
   logic [mf3_pkg::POS_W-1:0]  center_row;
   logic [mf3_pkg::POS_W-1:0]  center_col;
   logic                       last_of_frame;

   modport source (output valid, output median_value, output center_row,
                   output center_col, output last_of_frame, input ready);
   modport sink   (input valid, input median_value, input center_row,
                   input center_col, input last_of_frame, output ready);
endinterface

### design/mf3_csr.sv
// APB-style configuration registers (image_cols, image_rows) of the median
// filter, with the saturated working dimensions. Depends on mf3_pkg.
module mf3_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mf3_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mf3_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output mf3_pkg::dims_type                 dims
);

   logic [mf3_pkg::DIM_W-1:0] cols_raw_ff;
   logic [mf3_pkg::DIM_W-1:0] rows_raw_ff;
   mf3_pkg::dims_type         dims_ff;
   logic                      wr_en;
   logic                      reg_sel;
   logic [mf3_pkg::DIM_W-1:0] wr_val;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];
   assign wr_val     = csr_pwdata[mf3_pkg::DIM_W-1:0];
   assign dims       = dims_ff;

   // Write raw value and its saturated copy
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_raw_ff  <= mf3_pkg::COLS_RESET;
         rows_raw_ff  <= mf3_pkg::ROWS_RESET;
         dims_ff.cols <= mf3_pkg::COLS_RESET;
         dims_ff.rows <= mf3_pkg::ROWS_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            mf3_pkg::REG_IMAGE_COLS: begin
               cols_raw_ff  <= wr_val;
               dims_ff.cols <= mf3_pkg::clamp_dim(wr_val,
                                  mf3_pkg::DIM_W'(mf3_pkg::MAX_COLS));
            end
            mf3_pkg::REG_IMAGE_ROWS: begin
               rows_raw_ff  <= wr_val;
               dims_ff.rows <= mf3_pkg::clamp_dim(wr_val,
                                  mf3_pkg::DIM_W'(mf3_pkg::MAX_ROWS));
            end
            default: begin
            end
         endcase
      end
   end

   // Read back the raw register
   always_comb begin
      case (reg_sel)
         mf3_pkg::REG_IMAGE_COLS: csr_prdata = mf3_pkg::CSR_DATA_W'(cols_raw_ff);
         mf3_pkg::REG_IMAGE_ROWS: csr_prdata = mf3_pkg::CSR_DATA_W'(rows_raw_ff);
         default:                 csr_prdata = '0;
      endcase
   end

endmodule

### design/mf3_front.sv
// Front end of the median filter: raster counters, the two line buffers held
// in one read-modify-write memory, and the 3x3 window. Depends on mf3_pkg,
// mf3_req_if and median_filter_3x3_assert.svh.
`include "median_filter_3x3_assert.svh"

module mf3_front (
   input  logic              clock,
   input  logic              reset,
   mf3_req_if.sink           req,
   input  mf3_pkg::dims_type dims,
   output logic              win_valid,
   input  logic              win_ready,
   output mf3_pkg::win_type  win,
   output mf3_pkg::pos_type  win_pos
);

   // Raster counters
   logic [mf3_pkg::POS_W-1:0] row_ff, col_ff, row_in, col_in;
   logic [mf3_pkg::POS_W-1:0] r_cur, c_cur;
   logic [mf3_pkg::DIM_W-1:0] c_ext, r_ext;
   logic                      col_wrap, row_wrap, emit, last;

   // Handshake
   logic accept, en1, en2;

   // Memory stage: word is {upper row, middle row}
   logic [mf3_pkg::LB_WORD_W-1:0] lb_mem [0:mf3_pkg::MAX_COLS-1];
   logic [mf3_pkg::LB_WORD_W-1:0] rd_data_ff;
   logic [mf3_pkg::LB_WORD_W-1:0] fwd_data_ff;
   logic                          fwd_ff;
   logic                          s1_v_ff, s1_emit_ff;
   mf3_pkg::pix_type              s1_px_ff;
   logic [mf3_pkg::ADDR_W-1:0]    s1_addr_ff;
   mf3_pkg::pos_type              s1_pos_ff;
   mf3_pkg::pix_type              up_eff, mid_eff;
   logic [mf3_pkg::LB_WORD_W-1:0] wr_data;
   logic                          mem_we;

   // Window stage
   mf3_pkg::win_type window_ff;
   logic             s2_v_ff;
   mf3_pkg::pos_type s2_pos_ff;

   assign en2       = !s2_v_ff || win_ready;
   assign en1       = !s1_v_ff || en2;
   assign req.ready = en1;
   assign accept    = req.valid && en1;
   assign mem_we    = s1_v_ff && en2;

   // Position of the incoming pixel and the next counter values
   always_comb begin
      r_cur    = req.start_of_frame ? '0 : row_ff;
      c_cur    = req.start_of_frame ? '0 : col_ff;
      c_ext    = {1'b0, c_cur} + mf3_pkg::DIM_W'(1);
      r_ext    = {1'b0, r_cur} + mf3_pkg::DIM_W'(1);
      col_wrap = c_ext >= dims.cols;
      row_wrap = r_ext >= dims.rows;
      emit     = (r_cur >= mf3_pkg::POS_W'(2)) && (c_cur >= mf3_pkg::POS_W'(2));
      last     = ({1'b0, r_cur} == dims.rows - mf3_pkg::DIM_W'(1)) &&
                 ({1'b0, c_cur} == dims.cols - mf3_pkg::DIM_W'(1));
      if (col_wrap) begin
         col_in = '0;
         row_in = row_wrap ? '0 : r_ext[mf3_pkg::POS_W-1:0];
      end else begin
         col_in = c_ext[mf3_pkg::POS_W-1:0];
         row_in = r_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Take forwarded data when the previous transaction wrote the same column
   assign up_eff  = fwd_ff ? fwd_data_ff[mf3_pkg::LB_WORD_W-1:mf3_pkg::PIX_W]
                           : rd_data_ff[mf3_pkg::LB_WORD_W-1:mf3_pkg::PIX_W];
   assign mid_eff = fwd_ff ? fwd_data_ff[mf3_pkg::PIX_W-1:0]
                           : rd_data_ff[mf3_pkg::PIX_W-1:0];
   assign wr_data = {mid_eff, s1_px_ff};

   // Line buffer memory: read on accept, write back when the item leaves
   always_ff @(posedge clock) begin
      if (mem_we) begin
         lb_mem[s1_addr_ff] <= wr_data;
      end
      if (accept) begin
         rd_data_ff <= lb_mem[c_cur[mf3_pkg::ADDR_W-1:0]];
      end
   end

   // Memory stage control and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         fwd_ff  <= 1'b0;
      end else begin
         if (en1) begin
            s1_v_ff <= req.valid;
         end
         if (accept) begin
            fwd_ff <= s1_v_ff && (s1_addr_ff == c_cur[mf3_pkg::ADDR_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff      <= req.pixel;
         s1_addr_ff    <= c_cur[mf3_pkg::ADDR_W-1:0];
         s1_emit_ff    <= emit;
         s1_pos_ff.row <= r_cur - mf3_pkg::POS_W'(1);
         s1_pos_ff.col <= c_cur - mf3_pkg::POS_W'(1);
         s1_pos_ff.last <= last;
         fwd_data_ff   <= wr_data;
      end
   end

   // Shift the window left by one column for every transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         s2_v_ff   <= 1'b0;
      end else if (en2) begin
         s2_v_ff <= s1_v_ff && s1_emit_ff;
         if (s1_v_ff) begin
            window_ff[0] <= window_ff[1];
            window_ff[1] <= window_ff[2];
            window_ff[2] <= up_eff;
            window_ff[3] <= window_ff[4];
            window_ff[4] <= window_ff[5];
            window_ff[5] <= mid_eff;
            window_ff[6] <= window_ff[7];
            window_ff[7] <= window_ff[8];
            window_ff[8] <= s1_px_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && s1_v_ff) begin
         s2_pos_ff <= s1_pos_ff;
      end
   end

   assign win_valid = s2_v_ff;
   assign win       = window_ff;
   assign win_pos   = s2_pos_ff;

   `MF3_ASSERT_NEXT(a_s1_hold, clock, reset, s1_v_ff && !en2,
      $stable(s1_addr_ff) && $stable(s1_px_ff) && $stable(fwd_ff),
      "memory stage changed while stalled")
   `MF3_ASSERT_NEXT(a_fwd_hit, clock, reset,
      accept && s1_v_ff && (s1_addr_ff == c_cur[mf3_pkg::ADDR_W-1:0]),
      fwd_ff, "same-column access not forwarded")
   `MF3_ASSERT_IMPL(a_interior, clock, reset, s2_v_ff,
      (s2_pos_ff.row != '0) && (s2_pos_ff.col != '0),
      "border centre reached the median stage")

endmodule

### design/mf3_median.sv
// Median-of-nine sorting pipeline and output register of the median filter.
// Sorts each window column, combines the column extremes and medians, then
// takes the median of three. Depends on mf3_pkg and mf3_rsp_if.
module mf3_median (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mf3_pkg::win_type in_win,
   input  mf3_pkg::pos_type in_pos,
   mf3_rsp_if.source        rsp
);

   logic                   en3, en4, en5;
   logic                   v3_ff, v4_ff, v5_ff;
   mf3_pkg::col3_type      s3_col_ff [0:2];
   mf3_pkg::pos_type       s3_pos_ff, s4_pos_ff, s5_pos_ff;
   mf3_pkg::pix_type       s4_lo_ff, s4_md_ff, s4_hi_ff;
   mf3_pkg::pix_type       s5_med_ff;

   assign en5      = !v5_ff || rsp.ready;
   assign en4      = !v4_ff || en5;
   assign en3      = !v3_ff || en4;
   assign in_ready = en3;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en3) v3_ff <= in_valid;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // Sort each column of the window
   always_ff @(posedge clock) begin
      if (en3 && in_valid) begin
         for (int j = 0; j < 3; j++) begin
            s3_col_ff[j] <= mf3_pkg::sort3(in_win[j], in_win[3+j], in_win[6+j]);
         end
         s3_pos_ff <= in_pos;
      end
   end

   // Largest minimum, median of medians, smallest maximum
   always_ff @(posedge clock) begin
      if (en4 && v3_ff) begin
         s4_lo_ff  <= mf3_pkg::max2(mf3_pkg::max2(s3_col_ff[0].lo, s3_col_ff[1].lo),
                                    s3_col_ff[2].lo);
         s4_md_ff  <= mf3_pkg::med3(s3_col_ff[0].md, s3_col_ff[1].md, s3_col_ff[2].md);
         s4_hi_ff  <= mf3_pkg::min2(mf3_pkg::min2(s3_col_ff[0].hi, s3_col_ff[1].hi),
                                    s3_col_ff[2].hi);
         s4_pos_ff <= s3_pos_ff;
      end
   end

   // Final median into the output register
   always_ff @(posedge clock) begin
      if (en5 && v4_ff) begin
         s5_med_ff <= mf3_pkg::med3(s4_lo_ff, s4_md_ff, s4_hi_ff);
         s5_pos_ff <= s4_pos_ff;
      end
   end

   assign rsp.valid         = v5_ff;
   assign rsp.median_value  = s5_med_ff;
   assign rsp.center_row    = s5_pos_ff.row;
   assign rsp.center_col    = s5_pos_ff.col;
   assign rsp.last_of_frame = s5_pos_ff.last;

endmodule

### design/median_filter_3x3.sv
// 3x3 median filter over a raster pixel stream, one pixel per clock sustained while rsp takes results.
// A result leaves rsp after one line-buffer memory read, the window shift, and
// three compare stages of the sorter. Throughput is one transaction per cycle
// while rsp is not stalled: the line memory takes a read and a write-back each
// cycle, with forwarding between same-column transactions.
// Reset clears counters, window and pipeline; line memory keeps its contents.
module median_filter_3x3 (
   input  logic                              clock,
   input  logic                              reset,
   mf3_req_if.sink                           req_chan,
   mf3_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mf3_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mf3_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   mf3_pkg::dims_type dims;
   logic              win_valid, win_ready;
   mf3_pkg::win_type  win;
   mf3_pkg::pos_type  win_pos;

   // Configuration registers
   mf3_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .dims        (dims)
   );

   // Counters, line buffers and window
   mf3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .dims      (dims),
      .win_valid (win_valid),
      .win_ready (win_ready),
      .win       (win),
      .win_pos   (win_pos)
   );

   // Sorting pipeline and output register
   mf3_median u_median (
      .clock    (clock),
      .reset    (reset),
      .in_valid (win_valid),
      .in_ready (win_ready),
      .in_win   (win),
      .in_pos   (win_pos),
      .rsp      (rsp_chan)
   );

endmodule

### test/tb.sv
// Self-checking bench for median_filter_3x3: streams pixel frames, mirrors the
// line buffers and window per accepted transaction and checks every median.
// Depends on mf3_pkg and mf3_stream_if; drives the APB register port directly.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 1500;

   // Fixed opening sequence on a 4x3 frame: a full frame of extremes, part of a
   // second frame cut short by a start of frame, then a complete frame
   localparam logic [7:0] OPENING_PIXELS [28] = '{
      8'd0,   8'd255, 8'd0,   8'd255,
      8'd255, 8'd0,   8'd255, 8'd0,
      8'd0,   8'd0,   8'd255, 8'd255,
      8'd128, 8'd127, 8'd1,   8'd254,
      8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd0,   8'd0,   8'd255,
      8'd255, 8'd255, 8'd0,   8'd0
   };

   typedef struct packed {
      logic [mf3_pkg::PIX_W-1:0] median;
      logic [mf3_pkg::POS_W-1:0] row;
      logic [mf3_pkg::POS_W-1:0] col;
      logic                      last;
   } filter_result_type;

   // Mirror of the filter: line buffers, window, position counters and the
   // medians still owed by the block
   class median_mirror;
      logic [mf3_pkg::DIM_W-1:0] cols_reg;
      logic [mf3_pkg::DIM_W-1:0] rows_reg;
      logic [mf3_pkg::PIX_W-1:0] upper_line [mf3_pkg::MAX_COLS];
      logic [mf3_pkg::PIX_W-1:0] middle_line [mf3_pkg::MAX_COLS];
      logic [1:0]                visits [mf3_pkg::MAX_COLS];
      logic [mf3_pkg::PIX_W-1:0] window [9];
      logic [mf3_pkg::POS_W-1:0] row_pos;
      logic [mf3_pkg::POS_W-1:0] col_pos;
      filter_result_type         medians_due [$];
      int                        pixels_taken;
      int                        errors;

      function new();
         cols_reg = 12'd1024;
         rows_reg = 12'd768;
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
            visits[i]      = '0;
         end
         foreach (window[i]) window[i] = '0;
         row_pos      = '0;
         col_pos      = '0;
         pixels_taken = 0;
         errors       = 0;
      endfunction

      function void set_register(logic idx, logic [mf3_pkg::DIM_W-1:0] value);
         if (idx == mf3_pkg::REG_IMAGE_COLS) cols_reg = value;
         else rows_reg = value;
      endfunction

      function logic [mf3_pkg::DIM_W-1:0] register_value(logic idx);
         return (idx == mf3_pkg::REG_IMAGE_COLS) ? cols_reg : rows_reg;
      endfunction

      function int pending();
         return medians_due.size();
      endfunction

      // Saturate a dimension into [MIN_DIM, hi]
      function int limit_dim(logic [mf3_pkg::DIM_W-1:0] v, int hi);
         if (v < mf3_pkg::MIN_DIM) return mf3_pkg::MIN_DIM;
         if (v > hi) return hi;
         return int'(v);
      endfunction

      // True when every column below cols was written twice, so both line
      // buffers hold known data there
      function bit primed(int cols);
         for (int k = 0; k < cols; k++) begin
            if (visits[k] != 2'd2) return 1'b0;
         end
         return 1'b1;
      endfunction

      // Fifth smallest of the nine taps
      function logic [mf3_pkg::PIX_W-1:0] window_median();
         logic [mf3_pkg::PIX_W-1:0] s [9];
         logic [mf3_pkg::PIX_W-1:0] t;
         int a;
         int b;
         foreach (window[i]) s[i] = window[i];
         for (a = 1; a < 9; a++) begin
            t = s[a];
            b = a;
            while (b > 0 && s[b-1] > t) begin
               s[b] = s[b-1];
               b--;
            end
            s[b] = t;
         end
         return s[4];
      endfunction

      // Advance the mirror by one accepted pixel transaction
      function void take_pixel(logic [mf3_pkg::PIX_W-1:0] px, logic sof);
         int cols;
         int rows;
         int r;
         int c;
         logic [mf3_pkg::PIX_W-1:0] up;
         logic [mf3_pkg::PIX_W-1:0] mid;
         filter_result_type res;
         cols = limit_dim(cols_reg, mf3_pkg::MAX_COLS);
         rows = limit_dim(rows_reg, mf3_pkg::MAX_ROWS);
         pixels_taken++;
         if (sof) begin
            row_pos = '0;
            col_pos = '0;
         end
         r = int'(row_pos);
         c = int'(col_pos);

         // rotate the column through both line buffers
         up  = upper_line[c];
         mid = middle_line[c];
         upper_line[c]  = mid;
         middle_line[c] = px;
         if (visits[c] != 2'd2) visits[c] = visits[c] + 2'd1;

         // shift the window left, new column enters on the right
         window[0] = window[1];
         window[1] = window[2];
         window[2] = up;
         window[3] = window[4];
         window[4] = window[5];
         window[5] = mid;
         window[6] = window[7];
         window[7] = window[8];
         window[8] = px;

         if (r >= 2 && c >= 2) begin
            res.median = window_median();
            res.row    = mf3_pkg::POS_W'(r - 1);
            res.col    = mf3_pkg::POS_W'(c - 1);
            res.last   = (r == rows - 1) && (c == cols - 1);
            medians_due.insert(medians_due.size(), res);
         end

         // wrap column at row end and row at frame end
         if (c + 1 >= cols) begin
            col_pos = '0;
            row_pos = (r + 1 >= rows) ? '0 : mf3_pkg::POS_W'(r + 1);
         end else begin
            col_pos = mf3_pkg::POS_W'(c + 1);
         end
      endfunction

      // Compare one result transaction with the oldest median owed
      function void match_median(logic [mf3_pkg::PIX_W-1:0] median,
                                 logic [mf3_pkg::POS_W-1:0] row,
                                 logic [mf3_pkg::POS_W-1:0] col,
                                 logic last);
         filter_result_type want;
         if (medians_due.size() == 0) begin
            $error("unexpected result: center_row %0d center_col %0d median_value %0d",
                   row, col, median);
            errors++;
            return;
         end
         want = medians_due.pop_front();
         if (median !== want.median) begin
            $error("median_value: expected %0d, actual %0d", want.median, median);
            errors++;
         end
         if (row !== want.row) begin
            $error("center_row: expected %0d, actual %0d", want.row, row);
            errors++;
         end
         if (col !== want.col) begin
            $error("center_col: expected %0d, actual %0d", want.col, col);
            errors++;
         end
         if (last !== want.last) begin
            $error("last_of_frame: expected %0d, actual %0d", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [mf3_pkg::CSR_ADDR_W-1:0]    csr_paddr;
   logic [mf3_pkg::CSR_DATA_W-1:0]    csr_pwdata;
   logic [mf3_pkg::CSR_DATA_W-1:0]    csr_prdata;
   logic                              csr_pready;

   mf3_req_if req_bus ();
   mf3_rsp_if rsp_bus ();

   median_mirror mirror;
   int readback_errors;
   int burst_left;
   int random_sent;
   int quiet_cycles;

   median_filter_3x3 dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Read a register back and compare with the mirror's copy
   task automatic check_readback(input logic idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[mf3_pkg::DIM_W-1:0] !== mirror.register_value(idx)) begin
         $error("prdata[%0d]: expected %0d, actual %0d", idx,
                mirror.register_value(idx), csr_prdata[mf3_pkg::DIM_W-1:0]);
         readback_errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write a register through setup and access, then read it back
   task automatic write_register(input logic idx, input logic [mf3_pkg::DIM_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {20'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      mirror.set_register(idx, value);
      check_readback(idx);
   endtask

   // Offer one pixel, with bursts and random gaps, and hold until accepted
   task automatic send_pixel(input logic [mf3_pkg::PIX_W-1:0] px, input logic sof);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      req_bus.valid          <= 1'b1;
      req_bus.pixel          <= px;
      req_bus.start_of_frame <= sof;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      mirror.take_pixel(px, sof);
      burst_left--;
   endtask

   // Drop valid, drain all owed medians, then let the pipeline empty
   task automatic finish_phase();
      req_bus.valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [mf3_pkg::PIX_W-1:0] pick_pixel();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
      if (sel == 1) return 8'($urandom_range(126, 130));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [mf3_pkg::DIM_W-1:0] pick_dim();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return 12'($urandom_range(3, 9));
      if (sel == 7) return 12'($urandom_range(0, 2));
      if (sel == 8) return 12'($urandom_range(10, 40));
      return 12'($urandom_range(2048, 4095));
   endfunction

   // A run of random pixels opened by a start of frame
   task automatic send_frame(input int count);
      int i;
      for (i = 0; i < count; i++) send_pixel(8'($urandom_range(0, 255)), i == 0);
   endtask

   // New dimensions, then a run that may continue mid-frame or restart
   task automatic random_phase();
      int sel;
      int length;
      int i;
      logic fresh;
      sel = $urandom_range(0, 3);
      if (sel != 2) write_register(mf3_pkg::REG_IMAGE_COLS, pick_dim());
      if (sel != 1) write_register(mf3_pkg::REG_IMAGE_ROWS, pick_dim());
      length = $urandom_range(40, 140);
      fresh  = 1'($urandom_range(0, 1));
      // continue mid-frame only over columns both line buffers already hold
      if (!mirror.primed(mirror.limit_dim(mirror.cols_reg, mf3_pkg::MAX_COLS))) begin
         fresh = 1'b1;
      end
      for (i = 0; i < length; i++) begin
         send_pixel(pick_pixel(), (i == 0 && fresh) || ($urandom_range(0, 149) == 0));
         random_sent++;
      end
      finish_phase();
   endtask

   // Result receiver: segments of different stall patterns, one long hold
   initial begin
      int mode;
      int span;
      int i;
      bit held;
      held = 1'b0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held && mirror.pixels_taken >= 200) begin
            rsp_bus.ready <= 1'b0;
            repeat (200) @(posedge clock);
            held = 1'b1;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            for (i = 0; i < span; i++) begin
               case (mode)
                  0: rsp_bus.ready <= 1'b1;
                  1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                  2: rsp_bus.ready <= 1'($urandom_range(0, 1));
                  default: rsp_bus.ready <= ((i % 5) != 4);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Check every result transaction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         mirror.match_median(rsp_bus.median_value, rsp_bus.center_row,
                             rsp_bus.center_col, rsp_bus.last_of_frame);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int i;
      mirror          = new();
      readback_errors = 0;
      burst_left      = 0;
      random_sent     = 0;
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.pixel          <= '0;
      req_bus.start_of_frame <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of both registers
      check_readback(mf3_pkg::REG_IMAGE_COLS);
      check_readback(mf3_pkg::REG_IMAGE_ROWS);

      // opening sequence on a small frame
      write_register(mf3_pkg::REG_IMAGE_COLS, 12'd4);
      write_register(mf3_pkg::REG_IMAGE_ROWS, 12'd3);
      for (i = 0; i < 28; i++) send_pixel(OPENING_PIXELS[i], i == 0 || i == 16);
      finish_phase();

      // smallest frames: both dimensions saturate up to three
      write_register(mf3_pkg::REG_IMAGE_COLS, 12'd2);
      write_register(mf3_pkg::REG_IMAGE_ROWS, 12'd1);
      send_frame(9);
      send_frame(9);
      finish_phase();

      // tall strip: columns three, rows saturate down to the maximum
      write_register(mf3_pkg::REG_IMAGE_COLS, 12'd3);
      write_register(mf3_pkg::REG_IMAGE_ROWS, 12'hFFF);
      send_frame(300);
      finish_phase();

      // random dimensions and content
      while (random_sent < RANDOM_ITEMS) random_phase();
      repeat (20) @(posedge clock);

      if (mirror.errors == 0 && readback_errors == 0 && mirror.pending() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

### median_filter_3x3.f
+incdir+design
design/mf3_pkg.sv
design/mf3_stream_if.sv
design/mf3_csr.sv
design/mf3_front.sv
design/mf3_median.sv
design/median_filter_3x3.sv
test/tb.sv
